// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the request tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, ignored while reset is asserted
`define PRT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every rising edge, also during reset
`define PRT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PRT_ASSERT(name, clk, rst_n, prop, msg)
`define PRT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Types, codes and widths shared by the pending request tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prt_pkg;

  // Default table size
  localparam int PRT_TABLE_DEPTH = 16;

  // Field widths
  localparam int ID_W     = 16;
  localparam int CHAN_W   = 16;
  localparam int TIME_W   = 32;
  localparam int S_DATA_W = 104;  // 97 payload bits padded to whole bytes
  localparam int M_DATA_W = 32;

  // Item kinds on the slave side
  typedef enum logic [1:0] {
    MODE_ISSUE    = 2'd0,
    MODE_RESPONSE = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  // Result kinds on the master side
  typedef enum logic [2:0] {
    OC_ISSUED    = 3'd0,
    OC_REFUSED   = 3'd1,
    OC_FULL      = 3'd2,
    OC_COMPLETED = 3'd3,
    OC_UNMATCHED = 3'd4,
    OC_TIMEDOUT  = 3'd5,
    OC_DONE      = 3'd6
  } outcome_e;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Status flags returned by the arithmetic unit
  typedef struct packed {
    logic zero;
    logic neg;
  } alu_flags_t;

  // One table entry
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [CHAN_W-1:0] channel;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/pending_request_tracker_unit.sv
// ----------------------------------------------------------------------------
// pending_request_tracker_unit
// Outstanding request table with id allocation, response matching and
// timeout expiry, one entry per unstalled cycle via a shared subtractor.
// ----------------------------------------------------------------------------
//  Channel   Dir  Group                          Fields (tdata/tuser, low bit up)
//  s_axis    in   tvalid tready tdata tuser      tdata: channel, response_id,
//                                                timeout_ms, now_ms,
//                                                send_accepted; tuser: mode
//  m_axis    out  tvalid tready tdata tuser tlast tdata: request_id,
//                                                channel_out; tuser: outcome
//
// Issue passes through S_ISSUE, clear through S_FINAL. Response and tick walk
// the entries held in S_SCAN, one entry per cycle through the single table read
// port and the shared subtractor; all but a matched response end in S_FINAL.
// A result waiting on m_axis stalls the scan only when a new result is due.
// Reset empties the table at once (fill count cleared); no clearing pass.
// next_id restarts at 1 after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pending_request_tracker_unit #(
  parameter int TABLE_DEPTH = prt_pkg::PRT_TABLE_DEPTH
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // slave side
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // channel, response_id, timeout_ms, now_ms, send_accepted, zero pad
  input  wire  [prt_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  wire  [1:0]                     s_axis_tuser,
  // master side
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // request_id, channel_out
  output logic [prt_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // outcome
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             r_q, r_d;
  logic [CNT_W-1:0]             w_q, w_d;
  logic [CNT_W-1:0]             r_inc;
  logic                         found_q, found_d;
  logic [prt_pkg::ID_W-1:0]     next_id_q, next_id_d;

  // Latched transaction fields
  prt_pkg::mode_e               mode_q;
  logic [prt_pkg::CHAN_W-1:0]   chan_q;
  logic [prt_pkg::ID_W-1:0]     rid_q;
  logic [prt_pkg::TIME_W-1:0]   tmo_q;
  logic [prt_pkg::TIME_W-1:0]   now_q;
  logic                         acc_q;

  // Output register
  logic                         out_valid_q;
  prt_pkg::outcome_e            out_oc_q;
  logic [prt_pkg::ID_W-1:0]     out_id_q;
  logic [prt_pkg::CHAN_W-1:0]   out_chan_q;
  logic                         out_last_q;
  logic                         out_free;

  // Result to load
  logic                         emit;
  prt_pkg::outcome_e            emit_oc;
  logic [prt_pkg::ID_W-1:0]     emit_id;
  logic [prt_pkg::CHAN_W-1:0]   emit_chan;
  logic                         emit_last;

  // Table and arithmetic unit hookup
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  prt_pkg::entry_t              wr_data;
  logic [IDX_W-1:0]             rd_addr;
  prt_pkg::entry_t              rd_data;
  prt_pkg::alu_op_e             alu_op;
  logic [prt_pkg::TIME_W-1:0]   alu_a;
  logic [prt_pkg::TIME_W-1:0]   alu_b;
  logic [prt_pkg::TIME_W-1:0]   alu_res;
  prt_pkg::alu_flags_t          alu_flags;

  logic                         accept;
  logic                         advance;
  logic                         hit;
  logic                         full;

  prt_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  prt_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (count_q == CNT_W'(TABLE_DEPTH));
  assign r_inc         = r_q + CNT_W'(1);

  // Route operands to the shared unit
  always_comb begin
    alu_op = prt_pkg::ALU_SUB;
    alu_a  = now_q;
    alu_b  = rd_data.deadline;
    if (state_q == S_ISSUE) begin
      alu_op = prt_pkg::ALU_ADD;
      alu_b  = tmo_q;
    end else if (mode_q == prt_pkg::MODE_RESPONSE) begin
      alu_a = {rid_q, chan_q};
      alu_b = {rd_data.id, rd_data.channel};
    end
  end

  // Entry to be dropped by the current scan step
  always_comb begin
    case (mode_q)
      prt_pkg::MODE_RESPONSE: hit = !found_q && alu_flags.zero;
      prt_pkg::MODE_TICK:     hit = !alu_flags.neg;
      default:                hit = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    r_d       = r_q;
    w_d       = w_q;
    found_d   = found_q;
    next_id_d = next_id_q;
    emit      = 1'b0;
    emit_oc   = prt_pkg::OC_DONE;
    emit_id   = '0;
    emit_chan = '0;
    emit_last = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = w_q[IDX_W-1:0];
    wr_data   = rd_data;
    advance   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          r_d     = '0;
          w_d     = '0;
          found_d = 1'b0;
          case (prt_pkg::mode_e'(s_axis_tuser))
            prt_pkg::MODE_ISSUE:    state_d = S_ISSUE;
            prt_pkg::MODE_RESPONSE: state_d = S_SCAN;
            prt_pkg::MODE_TICK:     state_d = S_SCAN;
            default: begin
              count_d = '0;
              state_d = S_FINAL;
            end
          endcase
        end
      end

      // Allocate an id and append the entry (no id when full, no entry if refused)
      S_ISSUE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_chan = chan_q;
          state_d   = S_IDLE;
          if (full) begin
            emit_oc = prt_pkg::OC_FULL;
          end else begin
            emit_id   = next_id_q;
            next_id_d = (next_id_q == '1) ? prt_pkg::ID_W'(1)
                                          : next_id_q + prt_pkg::ID_W'(1);
            if (acc_q) begin
              emit_oc          = prt_pkg::OC_ISSUED;
              wr_en            = 1'b1;
              wr_addr          = count_q[IDX_W-1:0];
              wr_data.id       = next_id_q;
              wr_data.channel  = chan_q;
              wr_data.deadline = alu_res;
              count_d          = count_q + CNT_W'(1);
            end else begin
              emit_oc = prt_pkg::OC_REFUSED;
            end
          end
        end
      end

      // Walk the table oldest first, compacting kept entries
      S_SCAN: begin
        if (r_q == count_q) begin
          count_d = w_q;
          state_d = (mode_q == prt_pkg::MODE_RESPONSE && found_q) ? S_IDLE : S_FINAL;
        end else if (hit) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_id   = rd_data.id;
            emit_chan = rd_data.channel;
            found_d   = 1'b1;
            advance   = 1'b1;
            r_d       = r_inc;
            if (mode_q == prt_pkg::MODE_RESPONSE) begin
              emit_oc   = prt_pkg::OC_COMPLETED;
              emit_last = 1'b1;
            end else begin
              emit_oc   = prt_pkg::OC_TIMEDOUT;
              emit_last = 1'b0;
            end
          end
        end else begin
          wr_en   = (w_q != r_q);
          advance = 1'b1;
          r_d     = r_inc;
          w_d     = w_q + CNT_W'(1);
        end
      end

      // Closing result
      S_FINAL: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (mode_q == prt_pkg::MODE_RESPONSE) begin
            emit_oc   = prt_pkg::OC_UNMATCHED;
            emit_id   = rid_q;
            emit_chan = chan_q;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Read address: slot 0 while idle, next slot once a step completes
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = r_inc[IDX_W-1:0];
    end else begin
      rd_addr = r_q[IDX_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      r_q         <= '0;
      w_q         <= '0;
      found_q     <= 1'b0;
      next_id_q   <= prt_pkg::ID_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      r_q       <= r_d;
      w_q       <= w_d;
      found_q   <= found_d;
      next_id_q <= next_id_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the transaction fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= prt_pkg::mode_e'(s_axis_tuser);
      chan_q <= s_axis_tdata[15:0];
      rid_q  <= s_axis_tdata[31:16];
      tmo_q  <= s_axis_tdata[63:32];
      now_q  <= s_axis_tdata[95:64];
      acc_q  <= s_axis_tdata[96];
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_oc_q   <= emit_oc;
      out_id_q   <= emit_id;
      out_chan_q <= emit_chan;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_chan_q, out_id_q};
  assign m_axis_tuser  = out_oc_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  `PRT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(TABLE_DEPTH),
    "entry count above table depth")
  `PRT_ASSERT(a_compact_order, clk_i, rst_ni, (state_q == S_SCAN) |-> (w_q <= r_q),
    "compaction write index overtook read index")
  `PRT_ASSERT(a_id_nonzero, clk_i, rst_ni, next_id_q != '0,
    "next id is zero")
  `PRT_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> !s_axis_tready,
    "ready while a transaction is in progress")

endmodule

`default_nettype wire

// File: rtl/prt_alu.sv
// ----------------------------------------------------------------------------
// prt_alu
// Shared 32-bit adder/subtractor with zero and sign flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prt_alu (
  input  var prt_pkg::alu_op_e             op_i,
  input  wire  [prt_pkg::TIME_W-1:0]       a_i,
  input  wire  [prt_pkg::TIME_W-1:0]       b_i,
  output logic [prt_pkg::TIME_W-1:0]       res_o,
  output prt_pkg::alu_flags_t              flags_o
);

  // Add for deadlines, subtract for key match and expiry test
  always_comb begin
    case (op_i)
      prt_pkg::ALU_ADD: res_o = a_i + b_i;
      prt_pkg::ALU_SUB: res_o = a_i - b_i;
      default:          res_o = a_i - b_i;
    endcase
  end

  // Derive flags from the result
  assign flags_o.zero = (res_o == '0);
  assign flags_o.neg  = res_o[prt_pkg::TIME_W-1];

endmodule

`default_nettype wire

// File: rtl/prt_table.sv
// ----------------------------------------------------------------------------
// prt_table
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prt_table #(
  parameter int DEPTH = prt_pkg::PRT_TABLE_DEPTH,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                   clk_i,
  input  wire                   wr_en_i,
  input  wire  [IDX_W-1:0]      wr_addr_i,
  input  var prt_pkg::entry_t   wr_data_i,
  input  wire  [IDX_W-1:0]      rd_addr_i,
  output prt_pkg::entry_t       rd_data_o
);

  prt_pkg::entry_t mem [DEPTH];
  prt_pkg::entry_t rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: sim/tb_pending_request_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_pending_request_tracker_unit
// Self-checking bench for the pending request tracker. A directed table
// covers the field extremes, a full table, the expiry boundaries and clear.
// Random traffic follows. Each result is checked against its typed row
// value or a behavioural tracker kept in step with accepted transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_pending_request_tracker_unit;

  localparam int DEPTH        = prt_pkg::PRT_TABLE_DEPTH;
  localparam int ID_W         = prt_pkg::ID_W;
  localparam int CHAN_W       = prt_pkg::CHAN_W;
  localparam int TIME_W       = prt_pkg::TIME_W;
  localparam int RANDOM_ITEMS = 130;
  localparam int CALM_ITEMS   = 30;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int N_ROWS       = 26;

  // One result as the block reports it
  typedef struct {
    prt_pkg::outcome_e oc;
    logic [ID_W-1:0]   id;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } tracker_result_t;

  // One row of the directed table; the result is typed in where typed is set
  typedef struct {
    prt_pkg::mode_e    md;
    logic [CHAN_W-1:0] chan;
    logic [ID_W-1:0]   rid;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] now;
    logic              acc;
    int                reps;
    bit                typed;
    prt_pkg::outcome_e oc;
    logic [ID_W-1:0]   id;
    logic [CHAN_W-1:0] chan_out;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // channel, response_id, timeout_ms, now_ms, send_accepted, zero pad
  logic [prt_pkg::S_DATA_W-1:0] s_axis_tdata;
  // mode
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // request_id, channel_out
  logic [prt_pkg::M_DATA_W-1:0] m_axis_tdata;
  // outcome
  logic [2:0]                   m_axis_tuser;
  logic                         m_axis_tlast;

  // Behavioural tracker state
  logic [ID_W-1:0]   slot_id       [DEPTH];
  logic [CHAN_W-1:0] slot_chan     [DEPTH];
  logic [TIME_W-1:0] slot_deadline [DEPTH];
  int                slot_count = 0;
  logic [ID_W-1:0]   id_counter = 16'd1;
  tracker_result_t   awaited_results [$];

  int err_count     = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_due     = 1'b0;
  bit stall_done    = 1'b0;

  pending_request_tracker_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic queue_result(input prt_pkg::outcome_e oc, input logic [ID_W-1:0] id,
                              input logic [CHAN_W-1:0] chan, input logic last,
                              input bit keep);
    tracker_result_t r;
    r.oc   = oc;
    r.id   = id;
    r.chan = chan;
    r.last = last;
    if (keep) begin
      awaited_results.insert(awaited_results.size(), r);
    end
  endtask

  // Remove one entry and close the gap, keeping insertion order
  task automatic drop_slot(input int pos);
    int j;
    for (j = pos; j < slot_count - 1; j++) begin
      slot_id[j]       = slot_id[j+1];
      slot_chan[j]     = slot_chan[j+1];
      slot_deadline[j] = slot_deadline[j+1];
    end
    slot_count--;
  endtask

  // Advance the tracker by one accepted transaction and queue its results
  task automatic track_item(input prt_pkg::mode_e md, input logic [CHAN_W-1:0] chan,
                            input logic [ID_W-1:0] rid, input logic [TIME_W-1:0] tmo,
                            input logic [TIME_W-1:0] now, input logic acc,
                            input bit keep);
    int i;
    bit hit;
    logic [TIME_W-1:0] diff;
    case (md)
      prt_pkg::MODE_ISSUE: begin
        if (slot_count >= DEPTH) begin
          queue_result(prt_pkg::OC_FULL, '0, chan, 1'b1, keep);
        end else begin
          if (!acc) begin
            queue_result(prt_pkg::OC_REFUSED, id_counter, chan, 1'b1, keep);
          end else begin
            slot_id[slot_count]       = id_counter;
            slot_chan[slot_count]     = chan;
            slot_deadline[slot_count] = now + tmo;
            slot_count++;
            queue_result(prt_pkg::OC_ISSUED, id_counter, chan, 1'b1, keep);
          end
          // allocate the next id, skipping zero
          id_counter = id_counter + 16'd1;
          if (id_counter == '0) begin
            id_counter = 16'd1;
          end
        end
      end
      prt_pkg::MODE_RESPONSE: begin
        hit = 1'b0;
        for (i = 0; i < slot_count && !hit; i++) begin
          if (slot_id[i] == rid && slot_chan[i] == chan) begin
            queue_result(prt_pkg::OC_COMPLETED, slot_id[i], slot_chan[i], 1'b1, keep);
            drop_slot(i);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          queue_result(prt_pkg::OC_UNMATCHED, rid, chan, 1'b1, keep);
        end
      end
      prt_pkg::MODE_TICK: begin
        // expire, oldest first, every entry whose wrapped difference is not negative
        i = 0;
        while (i < slot_count) begin
          diff = now - slot_deadline[i];
          if (!diff[TIME_W-1]) begin
            queue_result(prt_pkg::OC_TIMEDOUT, slot_id[i], slot_chan[i], 1'b0, keep);
            drop_slot(i);
          end else begin
            i++;
          end
        end
        queue_result(prt_pkg::OC_DONE, '0, '0, 1'b1, keep);
      end
      default: begin
        slot_count = 0;
        queue_result(prt_pkg::OC_DONE, '0, '0, 1'b1, keep);
      end
    endcase
  endtask

  // Offer one transaction on the slave side; entered and left at a falling edge
  task automatic offer_item(input prt_pkg::mode_e md, input logic [CHAN_W-1:0] chan,
                            input logic [ID_W-1:0] rid, input logic [TIME_W-1:0] tmo,
                            input logic [TIME_W-1:0] now, input logic acc,
                            input bit keep);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= {7'b0, acc, now, tmo, rid, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_item(md, chan, rid, tmo, now, acc, keep);
    @(negedge clk_i);
  endtask

  // Result side back-pressure: random bursts, plus one long hold-off
  initial begin : result_sink
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_due && !stall_done) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest one awaited
  always @(posedge clk_i) begin : check_results
    tracker_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result outcome %0d id %h chan %h",
                                  m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]));
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser != want.oc) begin
          report_mismatch($sformatf("outcome %0d, expected %0d", m_axis_tuser, want.oc));
        end
        if (m_axis_tdata[15:0] != want.id) begin
          report_mismatch($sformatf("request_id %h, expected %h",
                                    m_axis_tdata[15:0], want.id));
        end
        if (m_axis_tdata[31:16] != want.chan) begin
          report_mismatch($sformatf("channel_out %h, expected %h",
                                    m_axis_tdata[31:16], want.chan));
        end
        if (m_axis_tlast != want.last) begin
          report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, want.last));
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("** pending_request_tracker_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t         rows [N_ROWS];
    int                r;
    int                k;
    int                n;
    int                pick;
    bit                issue_bias;
    prt_pkg::mode_e    md;
    logic [CHAN_W-1:0] chan;
    logic [ID_W-1:0]   rid;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] clock_ms;
    logic              acc;

    rows = '{
      // empty table: tick, clear and a stray response
      '{prt_pkg::MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_RESPONSE, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 1'b1, 1, 1'b1,
        prt_pkg::OC_UNMATCHED, 16'hFFFF, 16'hFFFF},
      // refused issue still uses an id; extremes of channel, timeout and time
      '{prt_pkg::MODE_ISSUE, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_REFUSED, 16'd1, 16'h0000},
      '{prt_pkg::MODE_ISSUE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b1,
        prt_pkg::OC_ISSUED, 16'd2, 16'hFFFF},
      '{prt_pkg::MODE_ISSUE, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b1, 1, 1'b1,
        prt_pkg::OC_ISSUED, 16'd3, 16'h0000},
      '{prt_pkg::MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h7FFF_FFFF, 1'b0, 1, 1'b0,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_RESPONSE, 16'hFFFF, 16'd2, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_COMPLETED, 16'd2, 16'hFFFF},
      // fill the table
      '{prt_pkg::MODE_ISSUE, 16'h00AA, 16'h0000, 32'd10, 32'd1000, 1'b1, 13, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_ISSUE, 16'h5555, 16'h0000, 32'h0, 32'd1005, 1'b1, 1, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_ISSUE, 16'h0F0F, 16'h0000, 32'h0, 32'd1009, 1'b1, 1, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_ISSUE, 16'hAAAA, 16'h0000, 32'h8000_0000, 32'd1000, 1'b1, 1, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      // full table rejects whatever the transport said
      '{prt_pkg::MODE_ISSUE, 16'h1234, 16'h0000, 32'h0, 32'h0, 1'b1, 1, 1'b1,
        prt_pkg::OC_FULL, 16'h0000, 16'h1234},
      '{prt_pkg::MODE_ISSUE, 16'h4321, 16'h0000, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_FULL, 16'h0000, 16'h4321},
      // id matches but channel does not, then a true match
      '{prt_pkg::MODE_RESPONSE, 16'h00AB, 16'd5, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_UNMATCHED, 16'd5, 16'h00AB},
      '{prt_pkg::MODE_RESPONSE, 16'h00AA, 16'd5, 32'h0, 32'h0, 1'b0, 1, 1'b0,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_ISSUE, 16'h3C3C, 16'h0000, 32'd1, 32'd1008, 1'b1, 1, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      // one short of a deadline, then expire a full table
      '{prt_pkg::MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'd1004, 1'b0, 1, 1'b1,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h8000_03E8, 1'b0, 1, 1'b0,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      // half-range difference reads as negative, so does minus one
      '{prt_pkg::MODE_ISSUE, 16'h0007, 16'h0000, 32'h0, 32'h0, 1'b1, 1, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h8000_0000, 1'b0, 1, 1'b1,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_RESPONSE, 16'h0007, 16'd21, 32'h0, 32'h0, 1'b0, 1, 1'b0,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      // clear drops a live entry
      '{prt_pkg::MODE_ISSUE, 16'h0001, 16'h0000, 32'd5, 32'd5, 1'b1, 1, 1'b0,
        prt_pkg::OC_ISSUED, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0, 1, 1'b1,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000},
      '{prt_pkg::MODE_RESPONSE, 16'h0001, 16'd22, 32'h0, 32'h0, 1'b0, 1, 1'b0,
        prt_pkg::OC_DONE, 16'h0000, 16'h0000}
    };

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;

    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    send_idle_pct = 25;
    recv_idle_pct = 25;
    for (r = 0; r < N_ROWS; r++) begin
      for (k = 0; k < rows[r].reps; k++) begin
        if (rows[r].typed) begin
          queue_result(rows[r].oc, rows[r].id, rows[r].chan_out, 1'b1, 1'b1);
        end
        offer_item(rows[r].md, rows[r].chan, rows[r].rid, rows[r].tmo, rows[r].now,
                   rows[r].acc, !rows[r].typed);
      end
    end

    // Random traffic around a clock that wraps part way through
    clock_ms   = 32'hFFFF_FC00 + 32'($urandom_range(0, 255));
    issue_bias = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0 && n < RANDOM_ITEMS - CALM_ITEMS) begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 3);
        recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 3);
        issue_bias    = 1'($urandom_range(0, 1));
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 40) begin
        stall_due = 1'b1;
      end
      clock_ms = clock_ms + 32'($urandom_range(0, 20));
      chan = 16'($urandom());
      rid  = 16'($urandom());
      tmo  = $urandom();
      now  = clock_ms;
      acc  = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 9) == 0) begin
        now = $urandom();
      end
      pick = $urandom_range(0, 99);
      if (pick < (issue_bias ? 60 : 38)) begin
        md = prt_pkg::MODE_ISSUE;
        if ($urandom_range(0, 9) < 7) begin
          chan = 16'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 9) != 0) begin
          tmo = 32'($urandom_range(0, 80));
        end
      end else if (pick < 80) begin
        md = prt_pkg::MODE_RESPONSE;
        // mostly answer a live entry, now and then with the wrong channel
        if (slot_count > 0 && $urandom_range(0, 3) != 0) begin
          k    = $urandom_range(0, slot_count - 1);
          rid  = slot_id[k];
          chan = slot_chan[k];
          if ($urandom_range(0, 9) == 0) begin
            chan[0] = ~chan[0];
          end
        end
      end else if (pick < 97) begin
        md = prt_pkg::MODE_TICK;
      end else begin
        md = prt_pkg::MODE_CLEAR;
      end
      offer_item(md, chan, rid, tmo, now, acc, 1'b1);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for a late stray result
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("** pending_request_tracker_unit: PASSED **");
    end else begin
      $display("** pending_request_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: pending_request_tracker_unit.f
+incdir+rtl
rtl/prt_pkg.sv
rtl/prt_alu.sv
rtl/prt_table.sv
rtl/pending_request_tracker_unit.sv
sim/tb_pending_request_tracker_unit.sv
